@@ hw/rtl/abm_pkg.sv @@
// shared types and constants of the audio block level meter
package abm_pkg;

    localparam int SAMPLE_BITS         = 24;
    localparam int LEVEL_BITS          = 24;
    localparam int COEF_BITS           = 16;
    localparam int SQ_BITS             = 2 * SAMPLE_BITS;
    localparam int SUM_BITS            = 60;
    localparam int ROOT_BITS           = SUM_BITS / 2;
    localparam int ITER_BITS           = $clog2(SUM_BITS);
    localparam int PROD_BITS           = LEVEL_BITS + COEF_BITS + 1;
    localparam int DEF_MAX_BLOCK_ITEMS = 4096;
    localparam int QUEUE_DEPTH         = 4;
    localparam int CFG_INDEX_BITS      = 2;

    localparam logic [LEVEL_BITS-1:0] FULL_SCALE = LEVEL_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [COEF_BITS:0]    COEF_ONE   = (COEF_BITS + 1)'(1) << COEF_BITS;
    localparam logic [PROD_BITS:0]    ROUND_HALF = (PROD_BITS + 1)'(1) << (COEF_BITS - 1);

    localparam logic [COEF_BITS-1:0] PEAK_DECAY_RESET    = 16'd63046;
    localparam logic [COEF_BITS-1:0] HOLD_DECAY_RESET    = 16'd65460;
    localparam logic [COEF_BITS-1:0] RMS_SMOOTHING_RESET = 16'd65156;
    localparam logic [COEF_BITS-1:0] MIN_RISE_RESET      = 16'd65460;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PEAK_DECAY,
        CFG_HOLD_DECAY,
        CFG_RMS_SMOOTHING,
        CFG_MIN_RISE
    } cfg_index_t;

    typedef struct packed {
        logic                   last;
        logic [SAMPLE_BITS-1:0] mag;
        logic [SQ_BITS-1:0]     sq;
    } abm_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } abm_queue_status_t;

endpackage

@@ hw/rtl/abm_if.sv @@
// sample and level channel interfaces
interface abm_sample_if import abm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;

    modport source (output valid, sample, block_end, input ready);
    modport sink   (input valid, sample, block_end, output ready);
endinterface

interface abm_level_if import abm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] peak_level;
    logic [LEVEL_BITS-1:0] hold_level;
    logic [LEVEL_BITS-1:0] rms_level;
    logic [LEVEL_BITS-1:0] rms_floor;

    modport source (output valid, peak_level, hold_level, rms_level, rms_floor, input ready);
    modport sink   (input valid, peak_level, hold_level, rms_level, rms_floor, output ready);
endinterface

@@ hw/rtl/abm_front.sv @@
// input stage: accepts samples, takes magnitude and square, feeds the queue
module abm_front import abm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    abm_sample_if.sink        audio,
    output logic              push,
    output abm_entry_t        push_data,
    input  abm_queue_status_t queue_status
);

    logic                   valid_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic                   last_reg;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_BITS-1:0]     sq;
    logic                   accept;

    assign mag = audio.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~audio.sample + 1'b1)
                                               : SAMPLE_BITS'(audio.sample);
    assign push        = valid_reg && !queue_status.full;
    assign audio.ready = !valid_reg || !queue_status.full;
    assign accept      = audio.valid && audio.ready;
    assign sq          = mag_reg * mag_reg;

    assign push_data.last = last_reg;
    assign push_data.mag  = mag_reg;
    assign push_data.sq   = sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg  <= mag;
            last_reg <= audio.block_end;
        end
    end

endmodule

@@ hw/rtl/abm_queue.sv @@
// short queue between the input stage and the block engine
module abm_queue import abm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  abm_entry_t        push_data,
    input  logic              pop,
    output abm_entry_t        pop_data,
    output abm_queue_status_t queue_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    abm_entry_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign queue_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign queue_status.empty = (count_reg == '0);
    assign pop_data           = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) push |-> (!queue_status.full || pop);
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_no_underflow;
        @(posedge clk) disable iff (!rst_n) pop |-> !queue_status.empty;
    endproperty
    a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(QUEUE_DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("queue count out of range");

endmodule

@@ hw/rtl/abm_back.sv @@
// block engine: accumulation, divide, square root, envelope update, output register
module abm_back import abm_pkg::*;
#(
    parameter int MAX_BLOCK_ITEMS = DEF_MAX_BLOCK_ITEMS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [COEF_BITS-1:0]      cfg_wdata,
    output logic                      pop,
    input  abm_entry_t                pop_data,
    input  abm_queue_status_t         queue_status,
    abm_level_if.source               meter
);

    localparam int CNT_W = $clog2(MAX_BLOCK_ITEMS + 1);
    localparam int REM_S_W = ROOT_BITS + 1;
    localparam int PART_S_W = ROOT_BITS + 3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_SQRT,
        S_PEAK,
        S_HOLD,
        S_AVG_OLD,
        S_AVG_NEW,
        S_AVG,
        S_MIN_CMP,
        S_MIN_ADD,
        S_OUT
    } state_t;

    state_t                state_reg;
    logic [ITER_BITS-1:0]  iter_reg;

    logic [COEF_BITS-1:0]  peak_decay_reg;
    logic [COEF_BITS-1:0]  hold_decay_reg;
    logic [COEF_BITS-1:0]  rms_smoothing_reg;
    logic [COEF_BITS-1:0]  min_rise_reg;

    logic [SAMPLE_BITS-1:0] block_max_reg;
    logic [SUM_BITS-1:0]    square_sum_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [LEVEL_BITS-1:0]  peak_env_reg;
    logic [LEVEL_BITS-1:0]  hold_env_reg;
    logic [LEVEL_BITS-1:0]  rms_avg_reg;
    logic [LEVEL_BITS-1:0]  rms_min_reg;

    logic                   out_valid_reg;
    logic [LEVEL_BITS-1:0]  out_peak_reg;
    logic [LEVEL_BITS-1:0]  out_hold_reg;
    logic [LEVEL_BITS-1:0]  out_rms_reg;
    logic [LEVEL_BITS-1:0]  out_floor_reg;

    logic [SUM_BITS-1:0]    work_reg;
    logic [CNT_W-1:0]       rem_d_reg;
    logic [REM_S_W-1:0]     rem_s_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [PROD_BITS-1:0]   acc_reg;

    logic [SUM_BITS:0]      sum_ext;
    logic [SUM_BITS-1:0]    sum_next;
    logic                   room;
    logic [CNT_W:0]         part_d;
    logic                   ge_d;
    logic [PART_S_W-1:0]    part_s;
    logic [PART_S_W-1:0]    trial_s;
    logic                   ge_s;
    logic [LEVEL_BITS-1:0]  mul_a;
    logic [COEF_BITS:0]     mul_b;
    logic [PROD_BITS:0]     avg_sum;
    logic [PROD_BITS:0]     rise_sum;
    logic [LEVEL_BITS-1:0]  rms;
    logic                   out_free;
    logic                   out_load;

    assign pop      = (state_reg == S_IDLE) && !queue_status.empty;
    assign room     = (count_reg < CNT_W'(MAX_BLOCK_ITEMS));
    assign sum_ext  = {1'b0, square_sum_reg} + (SUM_BITS + 1)'(pop_data.sq);
    assign sum_next = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];

    assign part_d  = {rem_d_reg, work_reg[SUM_BITS-1]};
    assign ge_d    = (part_d >= {1'b0, count_reg});
    assign part_s  = {rem_s_reg, work_reg[SUM_BITS-1 -: 2]};
    assign trial_s = {1'b0, root_reg, 2'b01};
    assign ge_s    = (part_s >= trial_s);
    assign rms     = root_reg[LEVEL_BITS-1:0];

    assign avg_sum  = {1'b0, acc_reg} + {1'b0, prod_reg} + ROUND_HALF;
    assign rise_sum = {1'b0, prod_reg} + ROUND_HALF;

    assign out_free = !out_valid_reg || meter.ready;
    assign out_load = (state_reg == S_OUT) && out_free;

    assign meter.valid      = out_valid_reg;
    assign meter.peak_level = out_peak_reg;
    assign meter.hold_level = out_hold_reg;
    assign meter.rms_level  = out_rms_reg;
    assign meter.rms_floor  = out_floor_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_PEAK:
            begin
                mul_a = peak_env_reg;
                mul_b = {1'b0, peak_decay_reg};
            end
            S_HOLD:
            begin
                mul_a = hold_env_reg;
                mul_b = {1'b0, hold_decay_reg};
            end
            S_AVG_OLD:
            begin
                mul_a = rms_avg_reg;
                mul_b = {1'b0, rms_smoothing_reg};
            end
            S_AVG_NEW:
            begin
                mul_a = rms;
                mul_b = COEF_ONE - {1'b0, rms_smoothing_reg};
            end
            S_MIN_CMP:
            begin
                mul_a = rms_avg_reg - rms_min_reg;
                mul_b = COEF_ONE - {1'b0, min_rise_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_decay_reg    <= PEAK_DECAY_RESET;
            hold_decay_reg    <= HOLD_DECAY_RESET;
            rms_smoothing_reg <= RMS_SMOOTHING_RESET;
            min_rise_reg      <= MIN_RISE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_PEAK_DECAY:    peak_decay_reg    <= cfg_wdata;
                CFG_HOLD_DECAY:    hold_decay_reg    <= cfg_wdata;
                CFG_RMS_SMOOTHING: rms_smoothing_reg <= cfg_wdata;
                CFG_MIN_RISE:      min_rise_reg      <= cfg_wdata;
                default:           min_rise_reg      <= min_rise_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            iter_reg       <= '0;
            block_max_reg  <= '0;
            square_sum_reg <= '0;
            count_reg      <= '0;
            peak_env_reg   <= '0;
            hold_env_reg   <= '0;
            rms_avg_reg    <= '0;
            rms_min_reg    <= FULL_SCALE;
            out_valid_reg  <= 1'b0;
            out_peak_reg   <= '0;
            out_hold_reg   <= '0;
            out_rms_reg    <= '0;
            out_floor_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && meter.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (pop_data.mag > block_max_reg)
                        begin
                            block_max_reg <= pop_data.mag;
                        end
                        if (room)
                        begin
                            square_sum_reg <= sum_next;
                            count_reg      <= count_reg + 1'b1;
                        end
                        if (pop_data.last)
                        begin
                            state_reg <= S_PREP;
                        end
                    end
                end
                S_PREP:
                begin
                    iter_reg  <= ITER_BITS'(SUM_BITS - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == '0)
                    begin
                        iter_reg  <= ITER_BITS'(ROOT_BITS - 1);
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == '0)
                    begin
                        state_reg <= S_PEAK;
                    end
                end
                S_PEAK:
                begin
                    state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    peak_env_reg <= (block_max_reg > peak_env_reg) ? block_max_reg
                                                                   : prod_reg[39:16];
                    state_reg    <= S_AVG_OLD;
                end
                S_AVG_OLD:
                begin
                    hold_env_reg <= (block_max_reg > hold_env_reg) ? block_max_reg
                                                                   : prod_reg[39:16];
                    state_reg    <= S_AVG_NEW;
                end
                S_AVG_NEW:
                begin
                    state_reg <= S_AVG;
                end
                S_AVG:
                begin
                    rms_avg_reg <= avg_sum[39:16];
                    state_reg   <= S_MIN_CMP;
                end
                S_MIN_CMP:
                begin
                    if (rms_avg_reg < rms_min_reg)
                    begin
                        rms_min_reg <= rms_avg_reg;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_MIN_ADD;
                    end
                end
                S_MIN_ADD:
                begin
                    rms_min_reg <= rms_min_reg + rise_sum[39:16];
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_peak_reg   <= peak_env_reg;
                        out_hold_reg   <= hold_env_reg;
                        out_rms_reg    <= rms_avg_reg;
                        out_floor_reg  <= rms_min_reg;
                        block_max_reg  <= '0;
                        square_sum_reg <= '0;
                        count_reg      <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // multiplier, divide and square root datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
        case (state_reg)
            S_PREP:
            begin
                work_reg  <= square_sum_reg;
                rem_d_reg <= '0;
                rem_s_reg <= '0;
                root_reg  <= '0;
            end
            S_DIV:
            begin
                rem_d_reg <= ge_d ? CNT_W'(part_d - {1'b0, count_reg}) : part_d[CNT_W-1:0];
                work_reg  <= {work_reg[SUM_BITS-2:0], ge_d};
            end
            S_SQRT:
            begin
                rem_s_reg <= ge_s ? REM_S_W'(part_s - trial_s) : part_s[REM_S_W-1:0];
                root_reg  <= {root_reg[ROOT_BITS-2:0], ge_s};
                work_reg  <= {work_reg[SUM_BITS-3:0], 2'b00};
            end
            S_AVG_NEW:
            begin
                acc_reg <= prod_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(MAX_BLOCK_ITEMS);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("sample count beyond limit");

    property p_block_cleared;
        @(posedge clk) disable iff (!rst_n)
            out_load |=> (count_reg == '0) && (square_sum_reg == '0) && (block_max_reg == '0);
    endproperty
    a_block_cleared: assert property (p_block_cleared) else $error("block state not cleared");

    property p_levels_bounded;
        @(posedge clk) disable iff (!rst_n)
            out_valid_reg |-> (out_peak_reg <= FULL_SCALE) && (out_hold_reg <= FULL_SCALE)
                              && (out_rms_reg <= FULL_SCALE);
    endproperty
    a_levels_bounded: assert property (p_levels_bounded) else $error("level above full scale");

    property p_floor_below_avg;
        @(posedge clk) disable iff (!rst_n) out_valid_reg |-> (out_floor_reg <= out_rms_reg);
    endproperty
    a_floor_below_avg: assert property (p_floor_below_avg) else $error("rms floor above average");

endmodule

@@ hw/rtl/audio_block_level_meter_unit.sv @@
// top level of the audio block level meter
//
// audio channel: signed samples, one per beat, block_end set on the last
// sample of a block. meter channel: one beat per block carrying the peak
// envelope, the peak hold, the averaged rms and the rms floor (Q1.23).
// cfg_we/cfg_addr/cfg_wdata write the four Q0.16 coefficients; write them
// only while no block is in flight.
// a sample that does not end a block is accumulated while the block engine
// stays idle. a block end raises the meter beat after it has passed through
// the input register and the queue, the divider load, the bit-serial divide
// of the square sum by the sample count, the square root at two bits per
// cycle, the envelope update through one shared multiplier and the load of
// the output register. meanwhile the input register and the four-beat queue
// take five more samples, then the audio channel stalls, since the engine
// takes no new sample until the beat of the block is loaded.
// a stalled meter channel holds its beat; the next block end waits for the
// output register while accumulation of later samples waits in the queue.
// reset loads the default coefficients, clears the block accumulators and
// envelopes and sets the rms floor to full scale.
module audio_block_level_meter_unit import abm_pkg::*;
#(
    parameter int MAX_BLOCK_ITEMS = DEF_MAX_BLOCK_ITEMS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    abm_sample_if.sink                audio,
    abm_level_if.source               meter,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [COEF_BITS-1:0]      cfg_wdata
);

    logic              push;
    abm_entry_t        push_data;
    logic              pop;
    abm_entry_t        pop_data;
    abm_queue_status_t queue_status;

    abm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .audio        (audio),
        .push         (push),
        .push_data    (push_data),
        .queue_status (queue_status)
    );

    abm_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .pop          (pop),
        .pop_data     (pop_data),
        .queue_status (queue_status)
    );

    abm_back #(
        .MAX_BLOCK_ITEMS (MAX_BLOCK_ITEMS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .pop          (pop),
        .pop_data     (pop_data),
        .queue_status (queue_status),
        .meter        (meter)
    );

endmodule

@@ tb/sv/audio_block_level_meter_unit_tb.sv @@
// self-checking testbench of the audio block level meter with a bit-exact level predictor
module audio_block_level_meter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import abm_pkg::*;

    localparam longint unsigned BLOCK_CAP     = DEF_MAX_BLOCK_ITEMS;
    localparam longint unsigned SUM_CEIL      = (64'd1 << SUM_BITS) - 64'd1;
    localparam int              SETTLE_CYCLES = 200;
    localparam int              IDLE_PCT      = 19;
    localparam int              LONG_LEN      = 200;

    typedef struct {
        logic [LEVEL_BITS-1:0] peak;
        logic [LEVEL_BITS-1:0] hold;
        logic [LEVEL_BITS-1:0] rms;
        logic [LEVEL_BITS-1:0] floor_lvl;
    } level_set_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_addr;
    logic [COEF_BITS-1:0]      cfg_wdata;

    abm_sample_if audio_if ();
    abm_level_if  meter_if ();

    audio_block_level_meter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .audio     (audio_if),
        .meter     (meter_if),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    longint unsigned k_peak, k_hold, k_smooth, k_rise;
    longint unsigned cur_peak_mag, energy_sum, energy_count;
    longint unsigned peak_track, hold_track, rms_track, floor_track;

    level_set_t expected_levels[$];
    int         level_errors = 0;
    bit         steady_flow  = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = ROOT_BITS - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic reset_levels();
        k_peak       = PEAK_DECAY_RESET;
        k_hold       = HOLD_DECAY_RESET;
        k_smooth     = RMS_SMOOTHING_RESET;
        k_rise       = MIN_RISE_RESET;
        cur_peak_mag = 0;
        energy_sum   = 0;
        energy_count = 0;
        peak_track   = 0;
        hold_track   = 0;
        rms_track    = 0;
        floor_track  = FULL_SCALE;
    endtask

    function automatic void fold_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic e);
        longint          sv;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned rms;
        level_set_t      lv;
        sv  = s;
        mag = (sv < 0) ? -sv : sv;
        if (mag > cur_peak_mag)
            cur_peak_mag = mag;
        if (energy_count < BLOCK_CAP)
        begin
            sq = mag * mag;
            energy_sum = (sq > SUM_CEIL - energy_sum) ? SUM_CEIL : energy_sum + sq;
            energy_count++;
        end
        if (!e)
            return;

        rms = floor_root(energy_sum / energy_count);
        peak_track = (cur_peak_mag > peak_track) ? cur_peak_mag
                                                 : (peak_track * k_peak) >> COEF_BITS;
        hold_track = (cur_peak_mag > hold_track) ? cur_peak_mag
                                                 : (hold_track * k_hold) >> COEF_BITS;
        rms_track = (rms_track * k_smooth + rms * (COEF_ONE - k_smooth) + ROUND_HALF)
                    >> COEF_BITS;
        if (rms_track < floor_track)
            floor_track = rms_track;
        else
            floor_track = floor_track
                + (((rms_track - floor_track) * (COEF_ONE - k_rise) + ROUND_HALF) >> COEF_BITS);

        cur_peak_mag = 0;
        energy_sum   = 0;
        energy_count = 0;

        lv.peak      = peak_track[LEVEL_BITS-1:0];
        lv.hold      = hold_track[LEVEL_BITS-1:0];
        lv.rms       = rms_track[LEVEL_BITS-1:0];
        lv.floor_lvl = floor_track[LEVEL_BITS-1:0];
        expected_levels.push_back(lv);
    endfunction

    task automatic check_field(input string name, input logic [LEVEL_BITS-1:0] want,
                               input logic [LEVEL_BITS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            level_errors++;
        end
    endtask

    // meter side: random stalls and scoreboard
    always @(posedge clk)
    begin : meter_check
        level_set_t want;
        if (rst_n && meter_if.valid && meter_if.ready)
        begin
            if (expected_levels.size() == 0)
            begin
                $display("%0t: meter beat with nothing pending, expected none got %0d %0d %0d %0d",
                         $time, meter_if.peak_level, meter_if.hold_level,
                         meter_if.rms_level, meter_if.rms_floor);
                level_errors++;
            end
            else
            begin
                want = expected_levels.pop_front();
                check_field("peak_level", want.peak, meter_if.peak_level);
                check_field("hold_level", want.hold, meter_if.hold_level);
                check_field("rms_level", want.rms, meter_if.rms_level);
                check_field("rms_floor", want.floor_lvl, meter_if.rms_floor);
            end
        end
        meter_if.ready <= rst_n && (steady_flow || $urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic e);
        if (!steady_flow)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                audio_if.valid <= 1'b0;
                @(posedge clk);
            end
        audio_if.valid     <= 1'b1;
        audio_if.sample    <= s;
        audio_if.block_end <= e;
        do
            @(posedge clk);
        while (!audio_if.ready);
        fold_sample(s, e);
    endtask

    task automatic audio_quiet();
        audio_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        audio_quiet();
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_coef(input cfg_index_t idx, input logic [COEF_BITS-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PEAK_DECAY:    k_peak   = v;
            CFG_HOLD_DECAY:    k_hold   = v;
            CFG_RMS_SMOOTHING: k_smooth = v;
            CFG_MIN_RISE:      k_rise   = v;
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_coefs(input logic [COEF_BITS-1:0] p, input logic [COEF_BITS-1:0] h,
                             input logic [COEF_BITS-1:0] sm, input logic [COEF_BITS-1:0] r);
        settle();
        write_coef(CFG_PEAK_DECAY, p);
        write_coef(CFG_HOLD_DECAY, h);
        write_coef(CFG_RMS_SMOOTHING, sm);
        write_coef(CFG_MIN_RISE, r);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int v;
        case ($urandom_range(9))
            0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2:       return '0;
            3, 4:
            begin
                v = int'($urandom_range(511)) - 256;
                return v[SAMPLE_BITS-1:0];
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_block(input int len);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(), i == len - 1);
    endtask

    task automatic test_directed();
        send_sample(24'sh7FFFFF, 1'b1);
        send_sample(24'sh800000, 1'b1);
        send_sample(24'sh000000, 1'b1);
        send_sample(-24'sd1, 1'b0);
        send_sample(24'sd1, 1'b0);
        send_sample(-24'sd1, 1'b1);
        send_sample(24'sh400000, 1'b0);
        send_sample(24'shC00000, 1'b0);
        send_sample(24'sh000000, 1'b0);
        send_sample(24'sh123456, 1'b1);
        send_sample(24'sh000000, 1'b0);
        send_sample(24'sh000000, 1'b1);
        // loud block after silence lifts the rms floor
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(24'sh800000, 1'b1);
        settle();
    endtask

    task automatic test_coef_extremes();
        logic [COEF_BITS-1:0] lo, hi;
        lo = '0;
        hi = '1;
        for (int k = 0; k < 4; k++)
        begin
            case (k)
                0: set_coefs(lo, lo, lo, lo);
                1: set_coefs(hi, hi, hi, hi);
                2: set_coefs(lo, hi, lo, hi);
                default: set_coefs(hi, lo, hi, lo);
            endcase
            for (int b = 0; b < 12; b++)
                send_block($urandom_range(1, 6));
        end
        settle();
    endtask

    task automatic test_long_blocks();
        int v;
        steady_flow = 1'b1;
        // two long blocks back to back, the loudest sample late in the second one
        for (int i = 0; i < LONG_LEN; i++)
        begin
            v = int'($urandom_range(2047)) - 1024;
            send_sample(v[SAMPLE_BITS-1:0], i == LONG_LEN - 1);
        end
        for (int i = 0; i < LONG_LEN + 7; i++)
        begin
            v = int'($urandom_range(2047)) - 1024;
            if (i == LONG_LEN + 2)
                v = -(1 << (SAMPLE_BITS - 1));
            send_sample(v[SAMPLE_BITS-1:0], i == LONG_LEN + 6);
        end
        settle();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_traffic();
        int sent;
        int len;
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 0)
                set_coefs(PEAK_DECAY_RESET, HOLD_DECAY_RESET, RMS_SMOOTHING_RESET,
                          MIN_RISE_RESET);
            else
                set_coefs(COEF_BITS'($urandom_range(65535)), COEF_BITS'($urandom_range(65535)),
                          COEF_BITS'($urandom_range(65535)), COEF_BITS'($urandom_range(65535)));
            sent = 0;
            while (sent < 150)
            begin
                case ($urandom_range(9))
                    0:       len = 1;
                    1, 2:    len = $urandom_range(9, 40);
                    default: len = $urandom_range(1, 8);
                endcase
                send_block(len);
                sent += len;
            end
        end
    endtask

    initial
    begin
        audio_if.valid     <= 1'b0;
        audio_if.sample    <= '0;
        audio_if.block_end <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_addr           <= CFG_PEAK_DECAY;
        cfg_wdata          <= '0;
        rst_n              <= 1'b0;
        reset_levels();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_coef_extremes();
        test_long_blocks();
        test_random_traffic();
        settle();

        if (level_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
